/* hdl/stereographic_ellipse_mapper_assert.svh */
// Assertion macros shared by the mapper RTL
`ifndef STEREOGRAPHIC_ELLIPSE_MAPPER_ASSERT_SVH
`define STEREOGRAPHIC_ELLIPSE_MAPPER_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define SEM_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SEM_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/sem_pkg.sv */
// Types, constants and clamp functions for the stereographic / ellipse mapper
package sem_pkg;

    localparam int COORD_W = 32;
    localparam int FRAC_W  = 16;
    localparam int RAD_W   = COORD_W - 1;
    localparam int NUM_W   = 80;
    localparam int DEN_W   = 64;
    localparam int QB      = 33;
    localparam int Q_W     = QB + 1;
    localparam int DIV_LAT = QB + 2;
    localparam int SUM_W   = 48;
    localparam int PROD_W  = 64;
    localparam int IDX_W   = 2;

    typedef enum logic [1:0] {
        OP_D2S = 2'd0,
        OP_S2D = 2'd1,
        OP_E2D = 2'd2,
        OP_D2E = 2'd3
    } op_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic [IDX_W-1:0] REG_CX = 2'd0;
    localparam logic [IDX_W-1:0] REG_CY = 2'd1;
    localparam logic [IDX_W-1:0] REG_RX = 2'd2;
    localparam logic [IDX_W-1:0] REG_RY = 2'd3;

    typedef struct packed {
        logic                sat;
        logic [COORD_W-1:0]  val;
    } clamp_t;

    typedef struct packed {
        op_t                       op;
        logic                      neg_x;
        logic                      neg_y;
        logic                      neg_z;
        logic                      div0;
        logic signed [SUM_W-1:0]   sum_x;
        logic signed [SUM_W-1:0]   sum_y;
    } side_t;

    // sign/magnitude quotient to a saturated two's complement field
    function automatic clamp_t clamp_mag(logic neg, logic ovf, logic [Q_W-1:0] q);
        clamp_t     c;
        logic [Q_W-1:0] lim;
        lim = neg ? (Q_W'(1) << (COORD_W - 1)) : ((Q_W'(1) << (COORD_W - 1)) - Q_W'(1));
        if (ovf || (q > lim))
        begin
            c.sat = 1'b1;
            c.val = neg ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end
        else
        begin
            c.sat = 1'b0;
            c.val = neg ? (COORD_W'(0) - q[COORD_W-1:0]) : q[COORD_W-1:0];
        end
        return c;
    endfunction

    // wide signed sum to a saturated field
    function automatic clamp_t clamp_sum(logic signed [SUM_W-1:0] s);
        clamp_t c;
        logic [SUM_W-COORD_W:0] top;
        top = s[SUM_W-1:COORD_W-1];
        if ((top == '0) || (top == '1))
        begin
            c.sat = 1'b0;
            c.val = s[COORD_W-1:0];
        end
        else
        begin
            c.sat = 1'b1;
            c.val = s[SUM_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end
        return c;
    endfunction

endpackage

/* hdl/sem_div.sv */
// Pipelined restoring divider, one quotient bit per stage, rounded result
module sem_div (
    input  logic                        clk,
    input  logic                        en,
    input  logic [sem_pkg::NUM_W-1:0]   num,
    input  logic [sem_pkg::DEN_W-1:0]   den,
    output logic                        ovf,
    output logic [sem_pkg::Q_W-1:0]     quo
);

    localparam int CW = sem_pkg::DEN_W + sem_pkg::QB;

    logic [sem_pkg::NUM_W-1:0] rem_reg [0:sem_pkg::QB];
    logic [sem_pkg::DEN_W-1:0] dv_reg  [0:sem_pkg::QB];
    logic [sem_pkg::QB-1:0]    q_reg   [0:sem_pkg::QB];
    logic [sem_pkg::QB:0]      ovf_reg;
    logic                      ovf_out_reg;
    logic [sem_pkg::Q_W-1:0]   quo_reg;
    logic                      rnd;

    // quotient must stay below 2^QB, else the result saturates anyway
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            dv_reg[0]  <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= CW'(num) >= (CW'(den) << sem_pkg::QB);
        end
    end

    for (genvar j = 1; j <= sem_pkg::QB; j++)
    begin : g_step
        localparam int BIT = sem_pkg::QB - j;
        logic [CW-1:0] dsh;
        logic          ge;

        assign dsh = CW'(dv_reg[j-1]) << BIT;
        assign ge  = CW'(rem_reg[j-1]) >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= ge ? (rem_reg[j-1] - dsh[sem_pkg::NUM_W-1:0]) : rem_reg[j-1];
                q_reg[j]   <= {q_reg[j-1][sem_pkg::QB-2:0], ge};
                dv_reg[j]  <= dv_reg[j-1];
                ovf_reg[j] <= ovf_reg[j-1];
            end
        end
    end

    // ties away from zero: round up when twice the remainder reaches the divisor
    assign rnd = {rem_reg[sem_pkg::QB], 1'b0} >= (sem_pkg::NUM_W + 1)'(dv_reg[sem_pkg::QB]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg     <= sem_pkg::Q_W'(q_reg[sem_pkg::QB]) + sem_pkg::Q_W'(rnd);
            ovf_out_reg <= ovf_reg[sem_pkg::QB];
        end
    end

    assign quo = quo_reg;
    assign ovf = ovf_out_reg;

endmodule

/* hdl/stereographic_ellipse_mapper.sv */
// Top level of the stereographic / ellipse point mapper
//
// Input channel: in_valid/in_ready carry one transaction of operation, in_x,
// in_y, in_z (signed Q15.16). Output channel: out_valid/out_ready carry out_x,
// out_y, out_z and status, one result per input, in order.
// Operations: disk to sphere, sphere to disk, ellipse to disk, disk to ellipse.
// Config: cfg_write/cfg_index/cfg_data set center_x, center_y, radius_x and
// radius_y; write them only while no transaction is in flight.
// Throughput: one transaction per cycle unless the output stalls. A result passes
// through five front stages, the 35-stage divider (one quotient bit per stage
// plus range check and rounding) and the output register before out_valid.
// The whole pipeline advances together; when out_valid is high and out_ready is
// low every stage holds and in_ready drops, so nothing is lost or repeated.
// Reset clears all valid bits and loads center 0 and radius 1.0.
`include "stereographic_ellipse_mapper_assert.svh"

module stereographic_ellipse_mapper (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [sem_pkg::IDX_W-1:0]          cfg_index,
    input  logic [sem_pkg::COORD_W-1:0]        cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         operation,
    input  logic signed [sem_pkg::COORD_W-1:0] in_x,
    input  logic signed [sem_pkg::COORD_W-1:0] in_y,
    input  logic signed [sem_pkg::COORD_W-1:0] in_z,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [sem_pkg::COORD_W-1:0] out_x,
    output logic signed [sem_pkg::COORD_W-1:0] out_y,
    output logic signed [sem_pkg::COORD_W-1:0] out_z,
    output logic [1:0]                         status
);

    localparam int CW  = sem_pkg::COORD_W;
    localparam int DW  = CW + 1;
    localparam int NW  = sem_pkg::NUM_W;
    localparam int DNW = sem_pkg::DEN_W;
    localparam int SW  = sem_pkg::SUM_W;
    localparam int PW  = sem_pkg::PROD_W;
    localparam int FW  = sem_pkg::FRAC_W;

    // configuration
    logic signed [CW-1:0]         cx_reg, cy_reg;
    logic [sem_pkg::RAD_W-1:0]    rx_reg, ry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
            rx_reg <= sem_pkg::RAD_W'(1) << FW;
            ry_reg <= sem_pkg::RAD_W'(1) << FW;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sem_pkg::REG_CX: cx_reg <= cfg_data;
                sem_pkg::REG_CY: cy_reg <= cfg_data;
                sem_pkg::REG_RX: rx_reg <= cfg_data[sem_pkg::RAD_W-1:0];
                sem_pkg::REG_RY: ry_reg <= cfg_data[sem_pkg::RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, out_valid_reg;
    logic [sem_pkg::DIV_LAT-1:0] vs_reg;

    logic adv;
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            vs_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            vs_reg        <= {vs_reg[sem_pkg::DIV_LAT-2:0], v5_reg};
            out_valid_reg <= vs_reg[sem_pkg::DIV_LAT-1];
        end
    end

    // stage 1: magnitudes, z + 1, point minus center
    sem_pkg::op_t         op1_reg, op2_reg, op3_reg, op4_reg;
    logic                 xn1_reg, yn1_reg, xn2_reg, yn2_reg, xn3_reg, yn3_reg;
    logic                 xn4_reg, yn4_reg;
    logic [CW-1:0]        xm1_reg, ym1_reg, xm2_reg, ym2_reg, xm3_reg, ym3_reg;
    logic [CW-1:0]        xm4_reg, ym4_reg;
    logic signed [DW-1:0] den1_reg, dx1_reg, dy1_reg;
    logic [CW-1:0]        xm_next, ym_next;
    logic signed [DW-1:0] den_next, dx_next, dy_next;

    always_comb
    begin
        xm_next  = in_x[CW-1] ? (CW'(0) - in_x) : in_x;
        ym_next  = in_y[CW-1] ? (CW'(0) - in_y) : in_y;
        den_next = DW'(in_z) + (DW'(1) <<< FW);
        dx_next  = DW'(in_x) - DW'(cx_reg);
        dy_next  = DW'(in_y) - DW'(cy_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op1_reg  <= sem_pkg::op_t'(operation);
            xn1_reg  <= in_x[CW-1];
            yn1_reg  <= in_y[CW-1];
            xm1_reg  <= xm_next;
            ym1_reg  <= ym_next;
            den1_reg <= den_next;
            dx1_reg  <= dx_next;
            dy1_reg  <= dy_next;
        end
    end

    // stage 2: squares or radius products, absolute values of the differences
    logic [PW-1:0]  px2_reg, py2_reg;
    logic [DW-1:0]  dm2_reg, dxm2_reg, dym2_reg, dm3_reg, dxm3_reg, dym3_reg;
    logic [DW-1:0]  dm4_reg, dxm4_reg, dym4_reg;
    logic           dn2_reg, dxn2_reg, dyn2_reg, dn3_reg, dxn3_reg, dyn3_reg;
    logic           dn4_reg, dxn4_reg, dyn4_reg;
    logic [CW-1:0]  mx_sel, my_sel;

    always_comb
    begin
        mx_sel = (op1_reg == sem_pkg::OP_D2S) ? xm1_reg : CW'(rx_reg);
        my_sel = (op1_reg == sem_pkg::OP_D2S) ? ym1_reg : CW'(ry_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px2_reg  <= PW'(xm1_reg) * PW'(mx_sel);
            py2_reg  <= PW'(ym1_reg) * PW'(my_sel);
            dn2_reg  <= den1_reg[DW-1];
            dxn2_reg <= dx1_reg[DW-1];
            dyn2_reg <= dy1_reg[DW-1];
            dm2_reg  <= den1_reg[DW-1] ? (DW'(0) - den1_reg) : den1_reg;
            dxm2_reg <= dx1_reg[DW-1] ? (DW'(0) - dx1_reg) : dx1_reg;
            dym2_reg <= dy1_reg[DW-1] ? (DW'(0) - dy1_reg) : dy1_reg;
            op2_reg  <= op1_reg;
            xn2_reg  <= xn1_reg;
            yn2_reg  <= yn1_reg;
            xm2_reg  <= xm1_reg;
            ym2_reg  <= ym1_reg;
        end
    end

    // stage 3: R^2 and rounded radius products
    logic [PW-1:0] r2_reg;
    logic [SW-1:0] tx3_reg, ty3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r2_reg   <= px2_reg + py2_reg;
            tx3_reg  <= SW'((px2_reg + (PW'(1) << (FW - 1))) >> FW);
            ty3_reg  <= SW'((py2_reg + (PW'(1) << (FW - 1))) >> FW);
            op3_reg  <= op2_reg;
            xn3_reg  <= xn2_reg;
            yn3_reg  <= yn2_reg;
            xm3_reg  <= xm2_reg;
            ym3_reg  <= ym2_reg;
            dn3_reg  <= dn2_reg;
            dxn3_reg <= dxn2_reg;
            dyn3_reg <= dyn2_reg;
            dm3_reg  <= dm2_reg;
            dxm3_reg <= dxm2_reg;
            dym3_reg <= dym2_reg;
        end
    end

    // stage 4: 1 + R^2, 1 - R^2, signed radius products
    logic [DNW-1:0]          den0_reg;
    logic signed [DNW:0]     diff_reg;
    logic signed [SW-1:0]    stx_reg, sty_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den0_reg <= r2_reg + (DNW'(1) << (2 * FW));
            diff_reg <= (DNW + 1)'(DNW'(1) << (2 * FW)) - (DNW + 1)'(r2_reg);
            stx_reg  <= xn3_reg ? (SW'(0) - tx3_reg) : tx3_reg;
            sty_reg  <= yn3_reg ? (SW'(0) - ty3_reg) : ty3_reg;
            op4_reg  <= op3_reg;
            xn4_reg  <= xn3_reg;
            yn4_reg  <= yn3_reg;
            xm4_reg  <= xm3_reg;
            ym4_reg  <= ym3_reg;
            dn4_reg  <= dn3_reg;
            dxn4_reg <= dxn3_reg;
            dyn4_reg <= dyn3_reg;
            dm4_reg  <= dm3_reg;
            dxm4_reg <= dxm3_reg;
            dym4_reg <= dym3_reg;
        end
    end

    // stage 5: divider operands per operation
    logic [NW-1:0]   nx_next, ny_next, nz_next;
    logic [DNW-1:0]  dvx_next, dvy_next, dvz_next;
    logic [DNW-1:0]  zmag;
    sem_pkg::side_t  side_next;
    logic [NW-1:0]   nx5_reg, ny5_reg, nz5_reg;
    logic [DNW-1:0]  dvx5_reg, dvy5_reg, dvz5_reg;
    sem_pkg::side_t  side5_reg;

    always_comb
    begin
        zmag            = diff_reg[DNW] ? DNW'(-diff_reg) : diff_reg[DNW-1:0];
        nx_next         = '0;
        ny_next         = '0;
        nz_next         = '0;
        dvx_next        = DNW'(1);
        dvy_next        = DNW'(1);
        dvz_next        = DNW'(1);
        side_next.op    = op4_reg;
        side_next.neg_x = xn4_reg;
        side_next.neg_y = yn4_reg;
        side_next.neg_z = 1'b0;
        side_next.div0  = 1'b0;
        side_next.sum_x = SW'(cx_reg) + stx_reg;
        side_next.sum_y = SW'(cy_reg) + sty_reg;
        unique case (op4_reg)
            sem_pkg::OP_D2S:
            begin
                nx_next         = NW'(xm4_reg) << (2 * FW + 1);
                ny_next         = NW'(ym4_reg) << (2 * FW + 1);
                nz_next         = NW'(zmag) << FW;
                dvx_next        = den0_reg;
                dvy_next        = den0_reg;
                dvz_next        = den0_reg;
                side_next.neg_z = diff_reg[DNW];
            end
            sem_pkg::OP_S2D:
            begin
                nx_next         = NW'(xm4_reg) << FW;
                ny_next         = NW'(ym4_reg) << FW;
                dvx_next        = (dm4_reg == '0) ? DNW'(1) : DNW'(dm4_reg);
                dvy_next        = dvx_next;
                side_next.neg_x = xn4_reg ^ dn4_reg;
                side_next.neg_y = yn4_reg ^ dn4_reg;
                side_next.div0  = (dm4_reg == '0);
            end
            sem_pkg::OP_E2D:
            begin
                nx_next         = NW'(dxm4_reg) << FW;
                ny_next         = NW'(dym4_reg) << FW;
                dvx_next        = (rx_reg == '0) ? DNW'(1) : DNW'(rx_reg);
                dvy_next        = (ry_reg == '0) ? DNW'(1) : DNW'(ry_reg);
                side_next.neg_x = dxn4_reg;
                side_next.neg_y = dyn4_reg;
                side_next.div0  = (rx_reg == '0) || (ry_reg == '0);
            end
            sem_pkg::OP_D2E: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nx5_reg   <= nx_next;
            ny5_reg   <= ny_next;
            nz5_reg   <= nz_next;
            dvx5_reg  <= dvx_next;
            dvy5_reg  <= dvy_next;
            dvz5_reg  <= dvz_next;
            side5_reg <= side_next;
        end
    end

    // dividers, with the side data delayed alongside
    logic                    ovf_x, ovf_y, ovf_z;
    logic [sem_pkg::Q_W-1:0] q_x, q_y, q_z;
    sem_pkg::side_t          side_reg [0:sem_pkg::DIV_LAT-1];

    sem_div u_div_x (.clk(clk), .en(adv), .num(nx5_reg), .den(dvx5_reg), .ovf(ovf_x), .quo(q_x));
    sem_div u_div_y (.clk(clk), .en(adv), .num(ny5_reg), .den(dvy5_reg), .ovf(ovf_y), .quo(q_y));
    sem_div u_div_z (.clk(clk), .en(adv), .num(nz5_reg), .den(dvz5_reg), .ovf(ovf_z), .quo(q_z));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side5_reg;
            for (int k = 1; k < sem_pkg::DIV_LAT; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // output stage: sign, clamp, status
    sem_pkg::side_t  sd;
    sem_pkg::clamp_t cmx, cmy, cmz, csx, csy;
    logic [CW-1:0]   ox_next, oy_next, oz_next;
    logic [1:0]      st_next;
    logic            sat;
    logic [CW-1:0]   out_x_reg, out_y_reg, out_z_reg;
    logic [1:0]      status_reg;
    sem_pkg::op_t    out_op_reg;

    always_comb
    begin
        sd      = side_reg[sem_pkg::DIV_LAT-1];
        cmx     = sem_pkg::clamp_mag(sd.neg_x, ovf_x, q_x);
        cmy     = sem_pkg::clamp_mag(sd.neg_y, ovf_y, q_y);
        cmz     = sem_pkg::clamp_mag(sd.neg_z, ovf_z, q_z);
        csx     = sem_pkg::clamp_sum(sd.sum_x);
        csy     = sem_pkg::clamp_sum(sd.sum_y);
        ox_next = cmx.val;
        oy_next = cmy.val;
        oz_next = '0;
        sat     = cmx.sat || cmy.sat;
        unique case (sd.op)
            sem_pkg::OP_D2S:
            begin
                oz_next = cmz.val;
                sat     = cmx.sat || cmy.sat || cmz.sat;
            end
            sem_pkg::OP_D2E:
            begin
                ox_next = csx.val;
                oy_next = csy.val;
                sat     = csx.sat || csy.sat;
            end
            default: ;
        endcase
        st_next = sat ? sem_pkg::ST_SAT : sem_pkg::ST_OK;
        if (sd.div0)
        begin
            ox_next = '0;
            oy_next = '0;
            oz_next = '0;
            st_next = sem_pkg::ST_DIV0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_x_reg  <= ox_next;
            out_y_reg  <= oy_next;
            out_z_reg  <= oz_next;
            status_reg <= st_next;
            out_op_reg <= sd.op;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign status    = status_reg;

    `SEM_ASSERT_IMP(a_div0_zero, out_valid_reg && (status_reg == sem_pkg::ST_DIV0),
        (out_x_reg == '0) && (out_y_reg == '0) && (out_z_reg == '0), "div0 result not zero")
    `SEM_ASSERT_IMP(a_z_only_d2s, out_valid_reg && (out_op_reg != sem_pkg::OP_D2S),
        out_z_reg == '0, "nonzero z outside disk to sphere")
    `SEM_ASSERT_IMP(a_d2e_no_div0, out_valid_reg && (out_op_reg == sem_pkg::OP_D2E),
        status_reg != sem_pkg::ST_DIV0, "disk to ellipse flagged division by zero")
    `SEM_ASSERT_NXT(a_stall_holds, !adv, $stable(v5_reg) && $stable(vs_reg),
        "pipeline moved during a stall")

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the stereographic / ellipse point mapper
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LAT  = 40;
    localparam int STALL_MAX = 5000;

    typedef struct {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [1:0]  st;
    } point_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [sem_pkg::IDX_W-1:0] cfg_index = '0;
    logic [sem_pkg::COORD_W-1:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  operation = sem_pkg::OP_D2S;
    logic signed [31:0] in_x = '0, in_y = '0, in_z = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic signed [31:0] out_x, out_y, out_z;
    logic [1:0]  status;

    // mapper register shadow
    logic [31:0] sh_cx, sh_cy;
    logic [30:0] sh_rx, sh_ry;

    point_res_t  pending_pts[$];
    bit          src_idle_en = 1'b1;
    bit          snk_idle_en = 1'b1;
    int          mismatches = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_div0 = 0;
    int          n_sat = 0;
    int          quiet_cycles = 0;
    int          op_hits[4] = '{0, 0, 0, 0};

    stereographic_ellipse_mapper dut (.*);

    always #4 clk = ~clk;

    function automatic logic [127:0] div_round(logic [127:0] n, logic [127:0] d);
        logic [127:0] q;
        logic [127:0] r;
        q = n / d;
        r = n % d;
        if ((r << 1) >= d)
            q = q + 1;
        return q;
    endfunction

    function automatic logic [127:0] mag_of(logic [31:0] v);
        logic signed [127:0] s;
        s = $signed(v);
        return (s < 0) ? $unsigned(-s) : $unsigned(s);
    endfunction

    function automatic logic signed [127:0] apply_sign(logic neg, logic [127:0] m);
        return neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [31:0] sat32(logic signed [127:0] v, inout logic sat);
        if (v > 128'sd2147483647)
        begin
            sat = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -128'sd2147483648)
        begin
            sat = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    function automatic point_res_t map_point(logic [1:0] op, logic [31:0] x,
                                             logic [31:0] y, logic [31:0] z);
        point_res_t  res;
        logic        sat;
        logic        xn, yn, dn;
        logic [127:0] xm, ym, r2, one2, den, zn, dm;
        logic signed [127:0] vx, vy, vz, ds;
        sat = 1'b0;
        res.st = sem_pkg::ST_OK;
        xn = x[31];
        yn = y[31];
        xm = mag_of(x);
        ym = mag_of(y);
        vx = 0;
        vy = 0;
        vz = 0;
        case (op)
            sem_pkg::OP_D2S:
            begin
                r2 = xm * xm + ym * ym;
                one2 = 128'd1 << 32;
                den = one2 + r2;
                vx = apply_sign(xn, div_round(xm << 33, den));
                vy = apply_sign(yn, div_round(ym << 33, den));
                if (one2 >= r2)
                    vz = apply_sign(1'b0, div_round((one2 - r2) << 16, den));
                else
                    vz = apply_sign(1'b1, div_round((r2 - one2) << 16, den));
            end
            sem_pkg::OP_S2D:
            begin
                ds = $signed(z) + 128'sd65536;
                if (ds == 0)
                    res.st = sem_pkg::ST_DIV0;
                else
                begin
                    dn = ds < 0;
                    dm = dn ? $unsigned(-ds) : $unsigned(ds);
                    vx = apply_sign(xn ^ dn, div_round(xm << 16, dm));
                    vy = apply_sign(yn ^ dn, div_round(ym << 16, dm));
                end
            end
            sem_pkg::OP_E2D:
            begin
                if (sh_rx == 0 || sh_ry == 0)
                    res.st = sem_pkg::ST_DIV0;
                else
                begin
                    ds = $signed(x) - $signed(sh_cx);
                    dm = (ds < 0) ? $unsigned(-ds) : $unsigned(ds);
                    vx = apply_sign(ds < 0, div_round(dm << 16, {97'd0, sh_rx}));
                    ds = $signed(y) - $signed(sh_cy);
                    dm = (ds < 0) ? $unsigned(-ds) : $unsigned(ds);
                    vy = apply_sign(ds < 0, div_round(dm << 16, {97'd0, sh_ry}));
                end
            end
            default:
            begin
                vx = $signed(sh_cx) + apply_sign(xn, (xm * sh_rx + 128'd32768) >> 16);
                vy = $signed(sh_cy) + apply_sign(yn, (ym * sh_ry + 128'd32768) >> 16);
            end
        endcase
        res.px = sat32(vx, sat);
        res.py = sat32(vy, sat);
        res.pz = sat32(vz, sat);
        if (sat && res.st == sem_pkg::ST_OK)
            res.st = sem_pkg::ST_SAT;
        return res;
    endfunction

    // one input transaction; payload is set on the edge that follows any gap
    task automatic send_point(logic [1:0] op, logic [31:0] x, logic [31:0] y,
                              logic [31:0] z);
        if (src_idle_en && $urandom_range(99) < 37)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 37);
        end
        in_valid <= 1'b1;
        operation <= op;
        in_x <= x;
        in_y <= y;
        in_z <= z;
        do
            @(posedge clk);
        while (!in_ready);
        pending_pts.push_back(map_point(op, x, y, z));
        op_hits[op]++;
        n_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_pts.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 5) @(posedge clk);
    endtask

    task automatic write_reg(logic [sem_pkg::IDX_W-1:0] idx, logic [31:0] val);
        drain_results();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            sem_pkg::REG_CX: sh_cx = val;
            sem_pkg::REG_CY: sh_cy = val;
            sem_pkg::REG_RX: sh_rx = val[30:0];
            default: sh_ry = val[30:0];
        endcase
    endtask

    task automatic set_ellipse(logic [31:0] cx, logic [31:0] cy, logic [31:0] rx,
                               logic [31:0] ry);
        write_reg(sem_pkg::REG_CX, cx);
        write_reg(sem_pkg::REG_CY, cy);
        write_reg(sem_pkg::REG_RX, rx);
        write_reg(sem_pkg::REG_RY, ry);
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(9))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2, 3: return $urandom();
            4: return {{8{1'b0}}, 24'($urandom())} ^ {32{1'($urandom_range(1))}};
            default: return {{14{1'b0}}, 18'($urandom())} ^ {32{1'($urandom_range(1))}};
        endcase
    endfunction

    task automatic test_directed();
        send_point(sem_pkg::OP_D2S, 32'h0, 32'h0, 32'h0);
        send_point(sem_pkg::OP_D2S, 32'h00010000, 32'hffff0000, 32'h0);
        send_point(sem_pkg::OP_D2S, 32'h7fffffff, 32'h80000000, 32'hffffffff);
        send_point(sem_pkg::OP_D2S, 32'h80000000, 32'h7fffffff, 32'h0);
        send_point(sem_pkg::OP_S2D, 32'h00008000, 32'hffff8000, 32'hffff0000);  // pole
        send_point(sem_pkg::OP_S2D, 32'h7fffffff, 32'h80000000, 32'hfffeffff);  // past pole
        send_point(sem_pkg::OP_S2D, 32'h00010000, 32'h00020000, 32'hfffe0000);  // z below -1
        send_point(sem_pkg::OP_S2D, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
        send_point(sem_pkg::OP_S2D, 32'h12345678, 32'hedcba987, 32'h80000000);
        send_point(sem_pkg::OP_E2D, 32'h7fffffff, 32'h80000000, 32'h0);
        send_point(sem_pkg::OP_D2E, 32'h80000000, 32'h7fffffff, 32'hffffffff);
        set_ellipse(32'h7fffffff, 32'h80000000, 32'h00000001, 32'h7fffffff);
        send_point(sem_pkg::OP_E2D, 32'h80000000, 32'h7fffffff, 32'h0);
        send_point(sem_pkg::OP_E2D, 32'h00000001, 32'hffffffff, 32'h0);
        send_point(sem_pkg::OP_D2E, 32'h7fffffff, 32'h80000000, 32'h0);
        send_point(sem_pkg::OP_D2E, 32'hffff8000, 32'h00008000, 32'h0);
        // zero radii
        set_ellipse(32'h00010000, 32'hffff0000, 32'h00000000, 32'h80000000);
        send_point(sem_pkg::OP_E2D, 32'h00020000, 32'h00020000, 32'h0);
        send_point(sem_pkg::OP_D2E, 32'h00020000, 32'hfffe0000, 32'h0);
        set_ellipse(32'h0, 32'h0, 32'h00010000, 32'h00000000);
        send_point(sem_pkg::OP_E2D, 32'h00020000, 32'h00020000, 32'h0);
        drain_results();
    endtask

    task automatic test_random_phase(int n_items);
        logic [1:0]  op;
        logic [31:0] z;
        for (int i = 0; i < n_items; i++)
        begin
            op = 2'($urandom_range(3));
            z = pick_coord();
            if (op == sem_pkg::OP_S2D && $urandom_range(9) == 0)
                z = 32'hffff0000 + $urandom_range(2) - 1;
            send_point(op, pick_coord(), pick_coord(), z);
        end
    endtask

    task automatic test_ellipse_settings();
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_ellipse($urandom(), $urandom(), $urandom(), $urandom());
                1: set_ellipse(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h00000001);
                2: set_ellipse(32'h0, 32'h0, 32'h00010000, 32'h00010000);
                3: set_ellipse(pick_coord(), pick_coord(), 32'h1 + $urandom_range(1 << 20),
                               32'h1 + $urandom_range(1 << 20));
                4: set_ellipse(pick_coord(), pick_coord(), $urandom(), 32'h0);
                default: set_ellipse($urandom(), $urandom(), {1'b0, 31'($urandom())} | 1,
                                     32'h00008000);
            endcase
            src_idle_en = (ph != 2);
            snk_idle_en = (ph != 2);
            test_random_phase(185);
        end
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
    endtask

    // sender sends short batches and holds off until the pipeline is empty after each
    task automatic test_empty_pipe_pause();
        for (int k = 0; k < 3; k++)
        begin
            test_random_phase(10);
            drain_results();
        end
        drain_results();
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            out_ready <= !(snk_idle_en && $urandom_range(99) < 37);
    end

    always @(posedge clk)
    begin
        point_res_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%h y=%h z=%h st=%0d",
                             out_x, out_y, out_z, status);
            end
            else
            begin
                e = pending_pts.pop_front();
                n_checked++;
                if (status == sem_pkg::ST_DIV0)
                    n_div0++;
                if (status == sem_pkg::ST_SAT)
                    n_sat++;
                if (out_x !== e.px || out_y !== e.py || out_z !== e.pz || status !== e.st)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch %0d: exp %h %h %h st=%0d got %h %h %h st=%0d",
                                 n_checked, e.px, e.py, e.pz, e.st,
                                 out_x, out_y, out_z, status);
                end
            end
        end
    end

    // watchdog on stalled traffic
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
                quiet_cycles <= 0;
            else if (pending_pts.size() != 0 || in_valid)
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_MAX)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        sh_cx = 32'h0;
        sh_cy = 32'h0;
        sh_rx = 31'h10000;
        sh_ry = 31'h10000;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_ellipse_settings();
        test_empty_pipe_pause();
        drain_results();
        $display("covered %0d points (ops %0d/%0d/%0d/%0d), %0d checked, %0d div0, %0d sat",
                 n_sent, op_hits[0], op_hits[1], op_hits[2], op_hits[3],
                 n_checked, n_div0, n_sat);
        if (mismatches == 0 && pending_pts.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
